### design/clnws_pkg.sv
// Package for the character LCD nibble write sequencer: codes, microcode word and program ROM.
package clnws_pkg;

  localparam int WAIT_W = 14;
  localparam int PC_W   = 5;

  // Fixed hold times, us
  localparam logic [WAIT_W-1:0] WAIT_POWER = WAIT_W'(15000);
  localparam logic [WAIT_W-1:0] WAIT_WAKE1 = WAIT_W'(4100);
  localparam logic [WAIT_W-1:0] WAIT_WAKE2 = WAIT_W'(100);

  // Register reset values
  localparam logic [WAIT_W-1:0] DATA_DELAY_RST  = WAIT_W'(46);
  localparam logic [WAIT_W-1:0] CMD_DELAY_RST   = WAIT_W'(40);
  localparam logic [WAIT_W-1:0] CLEAR_DELAY_RST = WAIT_W'(1640);

  // Cursor row base addresses
  localparam logic [7:0] ROW0_BASE = 8'h80;
  localparam logic [7:0] ROW1_BASE = 8'hC0;

  typedef enum logic [1:0] {
    MODE_INIT  = 2'd0,
    MODE_PRINT = 2'd1,
    MODE_MOVE  = 2'd2,
    MODE_CLEAR = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    REG_DATA_DELAY  = 2'd0,
    REG_CMD_DELAY   = 2'd1,
    REG_CLEAR_DELAY = 2'd2,
    REG_NONE        = 2'd3
  } reg_idx_t;

  // Event within one nibble frame
  typedef enum logic [1:0] {
    PH_SETUP  = 2'd0,
    PH_EN_HI  = 2'd1,
    PH_EN_LO  = 2'd2
  } phase_t;

  typedef enum logic [2:0] {
    NIB_CONST,
    NIB_CHAR_HI,
    NIB_CHAR_LO,
    NIB_ADDR_HI,
    NIB_ADDR_LO
  } nib_src_t;

  typedef enum logic [2:0] {
    DLY_POWER,
    DLY_WAKE1,
    DLY_WAKE2,
    DLY_DATA,
    DLY_CMD,
    DLY_CLEAR
  } dly_sel_t;

  typedef struct packed {
    nib_src_t   src;
    logic [3:0] konst;
    logic       rs;
    dly_sel_t   dly;
    logic       single;  // one event only, no enable pulse
    logic       last;    // final step of the program
  } uop_t;

  // Program entry points
  localparam logic [PC_W-1:0] PC_INIT  = PC_W'(0);
  localparam logic [PC_W-1:0] PC_PRINT = PC_W'(15);
  localparam logic [PC_W-1:0] PC_MOVE  = PC_W'(17);
  localparam logic [PC_W-1:0] PC_CLEAR = PC_W'(19);

  function automatic uop_t mk(nib_src_t src, logic [3:0] konst, logic rs,
                              dly_sel_t dly, logic single, logic last);
    uop_t u;
    u.src    = src;
    u.konst  = konst;
    u.rs     = rs;
    u.dly    = dly;
    u.single = single;
    u.last   = last;
    return u;
  endfunction

  function automatic logic [PC_W-1:0] entry(mode_t mode);
    logic [PC_W-1:0] pc;
    unique case (mode)
      MODE_INIT:  pc = PC_INIT;
      MODE_PRINT: pc = PC_PRINT;
      MODE_MOVE:  pc = PC_MOVE;
      MODE_CLEAR: pc = PC_CLEAR;
      default:    pc = PC_INIT;
    endcase
    return pc;
  endfunction

  // One step per nibble; a step emits three events unless single is set.
  function automatic uop_t uop_rom(logic [PC_W-1:0] pc);
    uop_t u;
    unique case (pc)
      // initialise: power-on wait, wake-up nibbles, then 0x32 0x28 0x08 0x01 0x06 0x0C
      5'd0:  u = mk(NIB_CONST,   4'h0, 1'b0, DLY_POWER, 1'b1, 1'b0);
      5'd1:  u = mk(NIB_CONST,   4'h3, 1'b0, DLY_WAKE1, 1'b0, 1'b0);
      5'd2:  u = mk(NIB_CONST,   4'h3, 1'b0, DLY_WAKE2, 1'b0, 1'b0);
      5'd3:  u = mk(NIB_CONST,   4'h3, 1'b0, DLY_WAKE2, 1'b0, 1'b0);
      5'd4:  u = mk(NIB_CONST,   4'h2, 1'b0, DLY_WAKE2, 1'b0, 1'b0);
      5'd5:  u = mk(NIB_CONST,   4'h2, 1'b0, DLY_CMD,   1'b0, 1'b0);
      5'd6:  u = mk(NIB_CONST,   4'h8, 1'b0, DLY_CMD,   1'b0, 1'b0);
      5'd7:  u = mk(NIB_CONST,   4'h0, 1'b0, DLY_CMD,   1'b0, 1'b0);
      5'd8:  u = mk(NIB_CONST,   4'h8, 1'b0, DLY_CMD,   1'b0, 1'b0);
      5'd9:  u = mk(NIB_CONST,   4'h0, 1'b0, DLY_CLEAR, 1'b0, 1'b0);
      5'd10: u = mk(NIB_CONST,   4'h1, 1'b0, DLY_CLEAR, 1'b0, 1'b0);
      5'd11: u = mk(NIB_CONST,   4'h0, 1'b0, DLY_CMD,   1'b0, 1'b0);
      5'd12: u = mk(NIB_CONST,   4'h6, 1'b0, DLY_CMD,   1'b0, 1'b0);
      5'd13: u = mk(NIB_CONST,   4'h0, 1'b0, DLY_CMD,   1'b0, 1'b0);
      5'd14: u = mk(NIB_CONST,   4'hC, 1'b0, DLY_CMD,   1'b0, 1'b1);
      // print character
      5'd15: u = mk(NIB_CHAR_HI, 4'h0, 1'b1, DLY_DATA,  1'b0, 1'b0);
      5'd16: u = mk(NIB_CHAR_LO, 4'h0, 1'b1, DLY_DATA,  1'b0, 1'b1);
      // move cursor
      5'd17: u = mk(NIB_ADDR_HI, 4'h0, 1'b0, DLY_CMD,   1'b0, 1'b0);
      5'd18: u = mk(NIB_ADDR_LO, 4'h0, 1'b0, DLY_CMD,   1'b0, 1'b1);
      // clear, then home to 0x80
      5'd19: u = mk(NIB_CONST,   4'h0, 1'b0, DLY_CLEAR, 1'b0, 1'b0);
      5'd20: u = mk(NIB_CONST,   4'h1, 1'b0, DLY_CLEAR, 1'b0, 1'b0);
      5'd21: u = mk(NIB_CONST,   4'h8, 1'b0, DLY_CMD,   1'b0, 1'b0);
      5'd22: u = mk(NIB_CONST,   4'h0, 1'b0, DLY_CMD,   1'b0, 1'b1);
      default: u = mk(NIB_CONST, 4'h0, 1'b0, DLY_CMD,   1'b1, 1'b1);
    endcase
    return u;
  endfunction

endpackage

### design/char_lcd_nibble_write_sequencer.sv
// Top level of the character LCD 4-bit write sequencer.
//
// Request words come in on s_*: s_tuser carries the request kind (init,
// print, move cursor, clear), s_tdata its operands. Each request becomes a
// run of pin-event words on m_*, one per display pin change, with m_tlast
// on the final event of the run. Every nibble is framed as setup, enable
// high, enable low, high nibble first.
//
// Rate: a request takes 6 (print, move), 12 (clear) or 43 (init) output
// words, one per cycle while m_tready is high; the cycle that takes a
// request emits no word. The rate is set by the microcode step and phase
// counters, which emit one event per cycle unless the output stalls.
// The request is registered first; its first word then enters the output register.
// s_tready drops while a request is in work and rises again as soon as the
// last event is loaded into the output register, so the next request can be
// taken while that word still waits.
// A stall on m_tready simply freezes the sequencer; nothing is dropped.
// Reset restores the delay registers (46, 40, 1640 us) and empties the
// output register. Configuration writes (cfg_*) are always ready and
// should be issued only while idle.
module char_lcd_nibble_write_sequencer (
  input  logic        clk,
  input  logic        rst,
  // request channel
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,    // char_code[7:0], row[8], column[14:9], zero[15]
  input  logic [1:0]  s_tuser,    // mode[1:0]
  // pin event channel
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,    // data_nibble[3:0], enable_level[4], wait_us[18:5], zero
  output logic        m_tuser,    // reg_select
  output logic        m_tlast,
  // configuration write channel
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [13:0] cfg_data
);

  localparam int WAIT_W = clnws_pkg::WAIT_W;
  localparam int PC_W   = clnws_pkg::PC_W;

  // delay registers
  logic [WAIT_W-1:0] data_delay;
  logic [WAIT_W-1:0] cmd_delay;
  logic [WAIT_W-1:0] clear_delay;

  // sequencer state
  logic                busy;
  logic [PC_W-1:0]     pc;
  clnws_pkg::phase_t   phase;
  logic [7:0]          char_code;
  logic [7:0]          addr;

  // output register
  logic                out_valid;
  logic [3:0]          out_nibble;
  logic                out_rs;
  logic                out_en;
  logic [WAIT_W-1:0]   out_wait;
  logic                out_last;

  clnws_pkg::uop_t     uop;
  logic [3:0]          nib;
  logic [WAIT_W-1:0]   wait_sel;
  logic                step_done;
  logic                load;
  logic                s_accept;
  logic [7:0]          row_base;

  assign s_tready  = !busy;
  assign cfg_ready = 1'b1;
  assign s_accept  = s_tvalid && s_tready;
  assign load      = busy && (!out_valid || m_tready);

  assign uop       = clnws_pkg::uop_rom(pc);
  assign step_done = uop.single || (phase == clnws_pkg::PH_EN_LO);
  assign row_base  = s_tdata[8] ? clnws_pkg::ROW1_BASE : clnws_pkg::ROW0_BASE;

  // nibble source select
  always_comb begin
    unique case (uop.src)
      clnws_pkg::NIB_CONST:   nib = uop.konst;
      clnws_pkg::NIB_CHAR_HI: nib = char_code[7:4];
      clnws_pkg::NIB_CHAR_LO: nib = char_code[3:0];
      clnws_pkg::NIB_ADDR_HI: nib = addr[7:4];
      clnws_pkg::NIB_ADDR_LO: nib = addr[3:0];
      default:                nib = uop.konst;
    endcase
  end

  // hold time select
  always_comb begin
    unique case (uop.dly)
      clnws_pkg::DLY_POWER: wait_sel = clnws_pkg::WAIT_POWER;
      clnws_pkg::DLY_WAKE1: wait_sel = clnws_pkg::WAIT_WAKE1;
      clnws_pkg::DLY_WAKE2: wait_sel = clnws_pkg::WAIT_WAKE2;
      clnws_pkg::DLY_DATA:  wait_sel = data_delay;
      clnws_pkg::DLY_CMD:   wait_sel = cmd_delay;
      clnws_pkg::DLY_CLEAR: wait_sel = clear_delay;
      default:              wait_sel = cmd_delay;
    endcase
  end

  // control and config
  always_ff @(posedge clk) begin
    if (rst) begin
      busy        <= 1'b0;
      pc          <= clnws_pkg::PC_INIT;
      phase       <= clnws_pkg::PH_SETUP;
      out_valid   <= 1'b0;
      data_delay  <= clnws_pkg::DATA_DELAY_RST;
      cmd_delay   <= clnws_pkg::CMD_DELAY_RST;
      clear_delay <= clnws_pkg::CLEAR_DELAY_RST;
    end else begin
      if (cfg_valid) begin
        case (clnws_pkg::reg_idx_t'(cfg_index))
          clnws_pkg::REG_DATA_DELAY:  data_delay  <= cfg_data;
          clnws_pkg::REG_CMD_DELAY:   cmd_delay   <= cfg_data;
          clnws_pkg::REG_CLEAR_DELAY: clear_delay <= cfg_data;
          default: ;
        endcase
      end

      // output register: the final word of a run may drain while idle
      if (load) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end

      if (s_accept) begin
        busy  <= 1'b1;
        pc    <= clnws_pkg::entry(clnws_pkg::mode_t'(s_tuser));
        phase <= clnws_pkg::PH_SETUP;
      end else if (load) begin
        if (step_done) begin
          phase <= clnws_pkg::PH_SETUP;
          pc    <= pc + PC_W'(1);
          if (uop.last) busy <= 1'b0;
        end else begin
          phase <= clnws_pkg::phase_t'(phase + 2'd1);
        end
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (s_accept) begin
      char_code <= s_tdata[7:0];
      addr      <= row_base + {2'b00, s_tdata[14:9]};
    end
    if (load) begin
      out_nibble <= nib;
      out_rs     <= uop.rs;
      out_en     <= (phase == clnws_pkg::PH_EN_HI);
      out_wait   <= wait_sel;
      out_last   <= uop.last && step_done;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {5'd0, out_wait, out_en, out_nibble};
  assign m_tuser  = out_rs;
  assign m_tlast  = out_last;

endmodule

### design/clnws_checker.sv
// Port-level checker for the character LCD sequencer, bound to the top level.
module clnws_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic [15:0] s_tdata,
  input logic [1:0]  s_tuser,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [23:0] m_tdata,
  input logic        m_tuser,
  input logic        m_tlast,
  input logic        cfg_valid,
  input logic        cfg_ready,
  input logic [1:0]  cfg_index,
  input logic [13:0] cfg_data
);

  // a taken request keeps the input closed for at least the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("s_tready high right after a request was taken");

  // when idle, only the final event of the previous run may be pending
  a_idle_only_last: assert property (@(posedge clk) disable iff (rst)
    s_tready && m_tvalid |-> m_tlast)
    else $error("input ready while a run is still in progress");

  // a run always ends with enable low
  a_last_enable_low: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tlast |-> !m_tdata[4])
    else $error("last event leaves enable high");

  // stalled output holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast)
                              && $stable(m_tuser))
    else $error("output word changed under stall");

  // reset empties the output
  a_reset_clear: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("output valid after reset");

endmodule

bind char_lcd_nibble_write_sequencer clnws_checker u_clnws_checker (.*);

### bench/testbench.sv
// Self-checking bench for the character LCD nibble write sequencer: request stream in, pin events out.
module testbench;

  // Request word as the bench sees it; packs into s_tdata / s_tuser
  typedef struct packed {
    clnws_pkg::mode_t mode;
    logic [7:0]       char_code;
    logic             row;
    logic [5:0]       column;
  } lcd_req_t;

  // One expected pin event, one output word
  typedef struct packed {
    logic [3:0]                   nib;
    logic                         rs;
    logic                         en;
    logic [clnws_pkg::WAIT_W-1:0] wait_us;
    logic                         last;
  } pin_event_t;

  // Instruction bytes of the LCD command set
  localparam logic [7:0] CMD_WAKE_4BIT = 8'h32;
  localparam logic [7:0] CMD_FUNC_SET  = 8'h28;
  localparam logic [7:0] CMD_DISP_OFF  = 8'h08;
  localparam logic [7:0] CMD_CLEAR     = 8'h01;
  localparam logic [7:0] CMD_ENTRY     = 8'h06;
  localparam logic [7:0] CMD_DISP_ON   = 8'h0C;
  localparam logic [7:0] CMD_HOME_ADDR = 8'h80;

  localparam int WAIT_W         = clnws_pkg::WAIT_W;
  localparam int IDLE_PCT       = 7;     // chance of an idle cycle, either side
  localparam int HOLD_AFTER_REQ = 150;   // accepted requests before the long output stall
  localparam int HOLD_CYCLES    = 500;
  localparam int DRAIN_CYCLES   = 20;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [15:0] s_tdata = '0;
  logic [1:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [23:0] m_tdata;
  logic        m_tuser;
  logic        m_tlast;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [13:0] cfg_data = '0;

  char_lcd_nibble_write_sequencer u_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Bench copy of the three hold-time registers, reset values
  logic [WAIT_W-1:0] dly_data  = clnws_pkg::DATA_DELAY_RST;
  logic [WAIT_W-1:0] dly_cmd   = clnws_pkg::CMD_DELAY_RST;
  logic [WAIT_W-1:0] dly_clear = clnws_pkg::CLEAR_DELAY_RST;

  lcd_req_t   pending_reqs[$];   // requests not yet offered
  pin_event_t lcd_events[$];     // pin events still owed by the block
  lcd_req_t   drv_req;
  int         req_accepted = 0;
  int         errors = 0;
  bit         steady = 1'b0;     // no idling on either side while set
  int         hold_left = 0;
  bit         hold_done = 1'b0;

  // ---------------------------------------------------------------------
  // Pin event predictor
  // ---------------------------------------------------------------------
  task automatic add_event(logic [3:0] nib, logic rs, logic en, logic [WAIT_W-1:0] w);
    pin_event_t ev;
    ev.nib     = nib;
    ev.rs      = rs;
    ev.en      = en;
    ev.wait_us = w;
    ev.last    = 1'b0;
    lcd_events.push_back(ev);
  endtask

  // setup, enable high, enable low; all three share the hold time
  task automatic add_nibble(logic [3:0] nib, logic rs, logic [WAIT_W-1:0] w);
    add_event(nib, rs, 1'b0, w);
    add_event(nib, rs, 1'b1, w);
    add_event(nib, rs, 1'b0, w);
  endtask

  task automatic add_byte(logic [7:0] b, logic rs, logic [WAIT_W-1:0] w);
    add_nibble(b[7:4], rs, w);
    add_nibble(b[3:0], rs, w);
  endtask

  task automatic expand_request(lcd_req_t r);
    pin_event_t tail;
    logic [7:0] addr;
    case (r.mode)
      clnws_pkg::MODE_INIT: begin
        // power-up wait with every pin low, then the wake-up sequence
        add_event(4'h0, 1'b0, 1'b0, clnws_pkg::WAIT_POWER);
        add_nibble(4'h3, 1'b0, clnws_pkg::WAIT_WAKE1);
        add_nibble(4'h3, 1'b0, clnws_pkg::WAIT_WAKE2);
        add_byte(CMD_WAKE_4BIT, 1'b0, clnws_pkg::WAIT_WAKE2);
        add_byte(CMD_FUNC_SET, 1'b0, dly_cmd);
        add_byte(CMD_DISP_OFF, 1'b0, dly_cmd);
        add_byte(CMD_CLEAR, 1'b0, dly_clear);
        add_byte(CMD_ENTRY, 1'b0, dly_cmd);
        add_byte(CMD_DISP_ON, 1'b0, dly_cmd);
      end
      clnws_pkg::MODE_PRINT: add_byte(r.char_code, 1'b1, dly_data);
      clnws_pkg::MODE_MOVE: begin
        // column adds onto the row base; the sum stays within 8 bits
        addr = (r.row ? clnws_pkg::ROW1_BASE : clnws_pkg::ROW0_BASE) + {2'b00, r.column};
        add_byte(addr, 1'b0, dly_cmd);
      end
      default: begin
        add_byte(CMD_CLEAR, 1'b0, dly_clear);
        add_byte(CMD_HOME_ADDR, 1'b0, dly_cmd);
      end
    endcase
    tail = lcd_events[lcd_events.size()-1];
    tail.last = 1'b1;
    lcd_events[lcd_events.size()-1] = tail;
  endtask

  // ---------------------------------------------------------------------
  // Request driver: offers queued requests, predicts on each accepted word
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        expand_request(drv_req);
        req_accepted++;
      end
      // a word on offer stays until taken
      if (!s_tvalid || s_tready) begin
        if (pending_reqs.size() != 0 && (steady || $urandom_range(0, 99) >= IDLE_PCT)) begin
          drv_req = pending_reqs.pop_front();
          s_tvalid <= 1'b1;
          s_tdata  <= {1'b0, drv_req.column, drv_req.row, drv_req.char_code};
          s_tuser  <= drv_req.mode;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Long output stall: once enough requests went in, hold m_tready low for
  // a stretch so the output register fills and s_tready drops
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end else if (!hold_done && req_accepted >= HOLD_AFTER_REQ) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end
  end

  // ---------------------------------------------------------------------
  // Pin event monitor
  // ---------------------------------------------------------------------
  task automatic check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin : mon
    pin_event_t got;
    pin_event_t want;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        got.nib     = m_tdata[3:0];
        got.en      = m_tdata[4];
        got.wait_us = m_tdata[18:5];
        got.rs      = m_tuser;
        got.last    = m_tlast;
        if (lcd_events.size() == 0) begin
          $display("%0t: pin event with none expected, expected nothing, actual %p", $time, got);
          errors++;
        end else begin
          want = lcd_events.pop_front();
          check_field("data_nibble", want.nib, got.nib);
          check_field("reg_select", want.rs, got.rs);
          check_field("enable_level", want.en, got.en);
          check_field("wait_us", want.wait_us, got.wait_us);
          check_field("last", want.last, got.last);
        end
      end
      m_tready <= (hold_left == 0) && (steady || $urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  // ---------------------------------------------------------------------
  // Stimulus and phases
  // ---------------------------------------------------------------------
  task automatic queue_req(clnws_pkg::mode_t mode, logic [7:0] ch, logic row,
                           logic [5:0] col);
    lcd_req_t r;
    r.mode      = mode;
    r.char_code = ch;
    r.row       = row;
    r.column    = col;
    pending_reqs.push_back(r);
  endtask

  // mostly short requests; init is long, so it gets a small share
  task automatic queue_random(int count);
    int pick;
    clnws_pkg::mode_t m;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(0, 99);
      m = (pick < 8)  ? clnws_pkg::MODE_INIT  :
          (pick < 50) ? clnws_pkg::MODE_PRINT :
          (pick < 80) ? clnws_pkg::MODE_MOVE  : clnws_pkg::MODE_CLEAR;
      queue_req(m, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                6'($urandom_range(0, 63)));
    end
  endtask

  // config only while idle; bench copy follows the accepted word
  task automatic write_reg(clnws_pkg::reg_idx_t idx, logic [13:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      clnws_pkg::REG_DATA_DELAY:  dly_data  = val;
      clnws_pkg::REG_CMD_DELAY:   dly_cmd   = val;
      clnws_pkg::REG_CLEAR_DELAY: dly_clear = val;
      default: ;       // unmapped index, ignored
    endcase
  endtask

  task automatic wait_drained();
    do @(posedge clk);
    while (pending_reqs.size() != 0 || s_tvalid || lcd_events.size() != 0);
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Reset values; directed corners of every field and every mode
    queue_req(clnws_pkg::MODE_INIT,  8'h00, 1'b0, 6'd0);
    queue_req(clnws_pkg::MODE_PRINT, 8'h00, 1'b0, 6'd0);
    queue_req(clnws_pkg::MODE_PRINT, 8'hFF, 1'b1, 6'd63);   // row/column ignored here
    queue_req(clnws_pkg::MODE_PRINT, 8'hA5, 1'b0, 6'd0);
    queue_req(clnws_pkg::MODE_PRINT, 8'h5A, 1'b0, 6'd0);
    queue_req(clnws_pkg::MODE_MOVE,  8'h00, 1'b0, 6'd0);
    queue_req(clnws_pkg::MODE_MOVE,  8'hFF, 1'b0, 6'd63);
    queue_req(clnws_pkg::MODE_MOVE,  8'h00, 1'b1, 6'd0);
    queue_req(clnws_pkg::MODE_MOVE,  8'h00, 1'b1, 6'd63);   // top of address space
    queue_req(clnws_pkg::MODE_MOVE,  8'h00, 1'b0, 6'd42);
    queue_req(clnws_pkg::MODE_CLEAR, 8'hFF, 1'b1, 6'd63);
    queue_req(clnws_pkg::MODE_CLEAR, 8'h00, 1'b0, 6'd0);
    queue_req(clnws_pkg::MODE_INIT,  8'hFF, 1'b1, 6'd63);
    wait_drained();

    // Zero hold times; write to the unmapped index must not land
    write_reg(clnws_pkg::REG_DATA_DELAY, 14'd0);
    write_reg(clnws_pkg::REG_CMD_DELAY, 14'd0);
    write_reg(clnws_pkg::REG_CLEAR_DELAY, 14'd0);
    write_reg(clnws_pkg::REG_NONE, 14'h3FFF);
    queue_req(clnws_pkg::MODE_INIT,  8'h00, 1'b0, 6'd0);
    queue_req(clnws_pkg::MODE_CLEAR, 8'h00, 1'b0, 6'd0);
    queue_req(clnws_pkg::MODE_PRINT, 8'h80, 1'b0, 6'd0);
    queue_req(clnws_pkg::MODE_MOVE,  8'h00, 1'b1, 6'd21);
    queue_random(100);
    wait_drained();

    // Maximum hold times, back to back with no idling; the long output
    // stall falls in this phase
    write_reg(clnws_pkg::REG_DATA_DELAY, 14'h3FFF);
    write_reg(clnws_pkg::REG_CMD_DELAY, 14'h3FFF);
    write_reg(clnws_pkg::REG_CLEAR_DELAY, 14'h3FFF);
    write_reg(clnws_pkg::REG_NONE, 14'd0);
    steady = 1'b1;
    queue_random(100);
    wait_drained();
    steady = 1'b0;

    // Random settings
    write_reg(clnws_pkg::REG_DATA_DELAY, 14'($urandom_range(0, 16383)));
    write_reg(clnws_pkg::REG_CMD_DELAY, 14'($urandom_range(0, 16383)));
    write_reg(clnws_pkg::REG_CLEAR_DELAY, 14'($urandom_range(0, 16383)));
    queue_random(150);
    wait_drained();

    write_reg(clnws_pkg::REG_CLEAR_DELAY, 14'($urandom_range(0, 16383)));
    write_reg(clnws_pkg::REG_DATA_DELAY, 14'($urandom_range(0, 16383)));
    write_reg(clnws_pkg::REG_CMD_DELAY, 14'($urandom_range(0, 16383)));
    queue_random(50);
    wait_drained();

    // let any stray word show up before judging
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (lcd_events.size() != 0) begin
      $display("%0t: pin events outstanding, expected 0, actual %0d", $time,
               lcd_events.size());
      errors++;
    end
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Watchdog, far above the slowest legal run
  initial begin
    #5_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

### files.f
design/clnws_pkg.sv
design/char_lcd_nibble_write_sequencer.sv
design/clnws_checker.sv
bench/testbench.sv
